// File: design/life_cellular_automaton_step_unit_macros.svh
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_unit_macros
// Assertion helpers shared by the step unit RTL.
// ----------------------------------------------------------------------------
`ifndef LIFE_CELLULAR_AUTOMATON_STEP_UNIT_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_STEP_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lca: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LCA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lca: next-cycle check failed");

`endif

// File: design/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants of the Life step unit: request and response
// payloads, configuration image, operation codes and register indexes.
// ----------------------------------------------------------------------------
package lca_pkg;

   localparam int GRID_W_DEFAULT = 32;
   localparam int GRID_H_DEFAULT = 32;

   localparam int STAG_LIMIT = 3;
   localparam logic [10:0] COUNT_MAX = 11'h7FF;
   localparam logic [7:0]  STAG_MAX  = 8'hFF;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_W   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_H   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_EDGES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIVE_COLOR = 3'd5;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_STEP    = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] cell_x;
      logic [4:0] cell_y;
      logic [1:0] write_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  read_value;
      logic [15:0] generation;
      logic [10:0] population;
      logic [10:0] births;
      logic [10:0] deaths;
      logic [7:0]  stagnation;
      logic        active;
   } rsp_type;

   typedef struct packed {
      logic [4:0] window_x;
      logic [4:0] window_y;
      logic [5:0] window_w;
      logic [5:0] window_h;
      logic       wrap_edges;
      logic [1:0] live_color;
   } cfg_type;

endpackage

// File: design/lca_csr.sv
// ----------------------------------------------------------------------------
// lca_csr
// Configuration registers of the Life step unit, written over a
// valid/ready channel that is always ready.
// ----------------------------------------------------------------------------
module lca_csr
   import lca_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_X:   cfg_in.window_x   = csr_data[4:0];
            CSR_WINDOW_Y:   cfg_in.window_y   = csr_data[4:0];
            CSR_WINDOW_W:   cfg_in.window_w   = csr_data[5:0];
            CSR_WINDOW_H:   cfg_in.window_h   = csr_data[5:0];
            CSR_WRAP_EDGES: cfg_in.wrap_edges = csr_data[0];
            CSR_LIVE_COLOR: cfg_in.live_color = csr_data[1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_x   <= '0;
         cfg_ff.window_y   <= '0;
         cfg_ff.window_w   <= '0;
         cfg_ff.window_h   <= '0;
         cfg_ff.wrap_edges <= 1'b1;
         cfg_ff.live_color <= 2'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/lca_mem.sv
// ----------------------------------------------------------------------------
// lca_mem
// Grid storage: the current generation plane and the next generation
// scratch plane, each one write port and one registered read port.
// ----------------------------------------------------------------------------
module lca_mem
   import lca_pkg::*;
#(
   parameter int DEPTH = GRID_W_DEFAULT * GRID_H_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
)
(
   input  logic          clock,
   input  logic          cur_re,
   input  logic [AW-1:0] cur_raddr,
   output logic [1:0]    cur_rdata,
   input  logic          cur_we,
   input  logic [AW-1:0] cur_waddr,
   input  logic [1:0]    cur_wdata,
   input  logic          nxt_re,
   input  logic [AW-1:0] nxt_raddr,
   output logic [1:0]    nxt_rdata,
   input  logic          nxt_we,
   input  logic [AW-1:0] nxt_waddr,
   input  logic [1:0]    nxt_wdata
);

   logic [1:0] cur_mem [DEPTH];
   logic [1:0] nxt_mem [DEPTH];
   logic [1:0] cur_rdata_ff;
   logic [1:0] nxt_rdata_ff;

   assign cur_rdata = cur_rdata_ff;
   assign nxt_rdata = nxt_rdata_ff;

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      if (cur_re) begin
         cur_rdata_ff <= cur_mem[cur_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         nxt_mem[nxt_waddr] <= nxt_wdata;
      end
      if (nxt_re) begin
         nxt_rdata_ff <= nxt_mem[nxt_raddr];
      end
   end

endmodule

// File: design/life_cellular_automaton_step_unit.sv
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_unit
// Life (B3/S23) engine over a GRID_W x GRID_H grid of 2-bit pixels with
// cell write, cell read, generation step and counter restart commands.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low; its single result
// appears on rsp_data for exactly one cycle with rsp_valid, and the receiver
// cannot stall it. A write or a restart answers in the next cycle and the
// block is ready again at once; a read answers from ST_READ, once the grid
// data is registered. A step sweeps an effective window of w x h cells: the
// single read port of the current-generation memory is swept three rows per
// column while a column window slides along each row, then the new
// generation is copied back from the scratch memory one cell per cycle.
// After reset, busy stays high while the grid is cleared.
// Configuration writes are taken at any time but should only happen idle.
// ----------------------------------------------------------------------------
`include "life_cellular_automaton_step_unit_macros.svh"

module life_cellular_automaton_step_unit
   import lca_pkg::*;
#(
   parameter int GRID_W = GRID_W_DEFAULT,
   parameter int GRID_H = GRID_H_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CELLS = GRID_W * GRID_H;
   localparam int AW    = $clog2(CELLS);
   localparam int XW    = $clog2(GRID_W + 1);
   localparam int YW    = $clog2(GRID_H + 1);
   localparam int CXW   = XW + 1;
   localparam int MW    = (XW > YW) ? XW : YW;
   localparam int EW    = ((MW > 6) ? MW : 6) + 1;

   // row taps of the sliding column window
   localparam logic [1:0] TAP_TOP = 2'd0;
   localparam logic [1:0] TAP_MID = 2'd1;
   localparam logic [1:0] TAP_BOT = 2'd2;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_COPY   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [XW-1:0]  w_ff, w_in;
   logic [YW-1:0]  h_ff, h_in;
   logic [YW-1:0]  j_ff, j_in;
   logic [CXW-1:0] c_ff, c_in;
   logic [1:0]     r_ff, r_in;
   logic           issue_ff, issue_in;
   logic           rd_grid_ff, rd_grid_in;

   // scan read pipeline metadata
   logic           v1_ff, v1_in;
   logic           dead1_ff, dead1_in;
   logic           last1_ff, last1_in;
   logic [1:0]     r1_ff, r1_in;
   logic [CXW-1:0] c1_ff, c1_in;
   logic [YW-1:0]  j1_ff, j1_in;
   logic [1:0]     col_ff, col_in;
   logic [2:0]     winl_ff, winl_in;
   logic [2:0]     winc_ff, winc_in;

   // copy pipeline metadata
   logic           cv_ff, cv_in;
   logic           clast_ff, clast_in;
   logic [AW-1:0]  caddr_ff, caddr_in;

   // statistics
   logic [15:0] gen_ff, gen_in;
   logic [10:0] pop_ff, pop_in;
   logic [10:0] born_ff, born_in;
   logic [10:0] died_ff, died_in;
   logic [10:0] ppop_ff, ppop_in;
   logic [10:0] pborn_ff, pborn_in;
   logic [10:0] pdied_ff, pdied_in;
   logic [7:0]  stag_ff, stag_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // memory ports
   logic          cur_re, cur_we, nxt_re, nxt_we;
   logic [AW-1:0] cur_raddr, cur_waddr, nxt_raddr, nxt_waddr;
   logic [1:0]    cur_rdata, cur_wdata, nxt_rdata, nxt_wdata;

   logic           accept;
   logic           in_grid;
   logic [AW-1:0]  cell_addr;
   logic [EW-1:0]  x0_e, y0_e, ww_e, hh_e, wlim_e, hlim_e, effw_e, effh_e;
   logic [XW-1:0]  coff, ax;
   logic [YW-1:0]  roff, ay;
   logic           cdead, rdead;
   logic [AW-1:0]  win_addr, cell_waddr;
   logic [CXW-1:0] c_wlast;
   logic           scan_last, copy_last;
   logic           live_bit, col_done, cell_do;
   logic [2:0]     full_col;
   logic [3:0]     nsum;
   logic           alive, keep;
   logic           stat_eq;
   logic [7:0]     stag_next;

   lca_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lca_mem #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .cur_re    (cur_re),
      .cur_raddr (cur_raddr),
      .cur_rdata (cur_rdata),
      .cur_we    (cur_we),
      .cur_waddr (cur_waddr),
      .cur_wdata (cur_wdata),
      .nxt_re    (nxt_re),
      .nxt_raddr (nxt_raddr),
      .nxt_rdata (nxt_rdata),
      .nxt_we    (nxt_we),
      .nxt_waddr (nxt_waddr),
      .nxt_wdata (nxt_wdata)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // addressed cell of a write or read command
   assign in_grid   = (int'(req_data.cell_x) < GRID_W) && (int'(req_data.cell_y) < GRID_H);
   assign cell_addr = AW'(int'(req_data.cell_y) * GRID_W + int'(req_data.cell_x));

   // effective window: zero size means the full grid, clip at the grid edge
   always_comb begin
      x0_e   = EW'(cfg.window_x);
      y0_e   = EW'(cfg.window_y);
      ww_e   = (cfg.window_w == '0) ? EW'(GRID_W) : EW'(cfg.window_w);
      hh_e   = (cfg.window_h == '0) ? EW'(GRID_H) : EW'(cfg.window_h);
      wlim_e = EW'(GRID_W) - x0_e;
      hlim_e = EW'(GRID_H) - y0_e;
      if (x0_e >= EW'(GRID_W) || y0_e >= EW'(GRID_H)) begin
         effw_e = '0;
         effh_e = '0;
      end else begin
         effw_e = (ww_e > wlim_e) ? wlim_e : ww_e;
         effh_e = (hh_e > hlim_e) ? hlim_e : hh_e;
      end
   end

   // scan column: first and last positions are the wrapped or dead halo
   assign c_wlast = CXW'(w_ff) + CXW'(1);

   always_comb begin
      if (c_ff == '0) begin
         coff  = XW'(w_ff - XW'(1));
         cdead = !cfg.wrap_edges;
      end else if (c_ff == c_wlast) begin
         coff  = '0;
         cdead = !cfg.wrap_edges;
      end else begin
         coff  = XW'(c_ff - CXW'(1));
         cdead = 1'b0;
      end
   end

   always_comb begin
      roff  = j_ff;
      rdead = 1'b0;
      case (r_ff)
         TAP_TOP: begin
            if (j_ff == '0) begin
               roff  = YW'(h_ff - YW'(1));
               rdead = !cfg.wrap_edges;
            end else begin
               roff = YW'(j_ff - YW'(1));
            end
         end
         TAP_MID: roff = j_ff;
         TAP_BOT: begin
            if (j_ff == YW'(h_ff - YW'(1))) begin
               roff  = '0;
               rdead = !cfg.wrap_edges;
            end else begin
               roff = YW'(j_ff + YW'(1));
            end
         end
         default: roff = j_ff;
      endcase
   end

   // one address generator serves the scan reads and the copy reads
   always_comb begin
      if (state_ff == ST_SCAN) begin
         ax = coff;
         ay = roff;
      end else begin
         ax = XW'(c_ff);
         ay = j_ff;
      end
   end

   assign win_addr = AW'((int'(cfg.window_y) + int'(ay)) * GRID_W
                         + int'(cfg.window_x) + int'(ax));

   assign scan_last = (r_ff == TAP_BOT) && (c_ff == c_wlast)
                      && (j_ff == YW'(h_ff - YW'(1)));
   assign copy_last = (c_ff == CXW'(w_ff) - CXW'(1)) && (j_ff == YW'(h_ff - YW'(1)));

   // neighborhood of the cell left of the newest column
   assign live_bit  = !dead1_ff && (cur_rdata == cfg.live_color);
   assign col_done  = v1_ff && (r1_ff == TAP_BOT);
   assign full_col  = {live_bit, col_ff[1], col_ff[0]};
   assign cell_do   = col_done && (c1_ff >= CXW'(2));
   assign nsum      = 4'(winl_ff[0]) + 4'(winl_ff[1]) + 4'(winl_ff[2])
                    + 4'(full_col[0]) + 4'(full_col[1]) + 4'(full_col[2])
                    + 4'(winc_ff[TAP_TOP]) + 4'(winc_ff[TAP_BOT]);
   assign alive     = winc_ff[TAP_MID];
   assign keep      = alive ? (nsum == 4'd2 || nsum == 4'd3) : (nsum == 4'd3);
   assign cell_waddr = AW'((int'(cfg.window_y) + int'(j1_ff)) * GRID_W
                           + int'(cfg.window_x) + int'(c1_ff) - 2);

   assign stat_eq   = (pop_ff == ppop_ff) && (born_ff == pborn_ff) && (died_ff == pdied_ff);
   assign stag_next = stat_eq ? ((stag_ff == STAG_MAX) ? stag_ff : stag_ff + 8'd1) : 8'd0;

   // memory port steering
   always_comb begin
      cur_re    = 1'b0;
      cur_raddr = win_addr;
      cur_we    = 1'b0;
      cur_waddr = cell_addr;
      cur_wdata = req_data.write_value;
      if (state_ff == ST_CLEAR) begin
         cur_we    = 1'b1;
         cur_waddr = clr_ff;
         cur_wdata = 2'd0;
      end else if (cv_ff) begin
         cur_we    = 1'b1;
         cur_waddr = caddr_ff;
         cur_wdata = nxt_rdata;
      end else if (state_ff == ST_IDLE) begin
         cur_raddr = cell_addr;
         cur_re    = accept && (req_data.op == OP_READ);
         cur_we    = accept && (req_data.op == OP_WRITE) && in_grid;
      end else if (state_ff == ST_SCAN) begin
         cur_re = issue_ff;
      end
   end

   assign nxt_re    = (state_ff == ST_COPY) && issue_ff;
   assign nxt_raddr = win_addr;
   assign nxt_we    = cell_do;
   assign nxt_waddr = cell_waddr;
   assign nxt_wdata = keep ? cfg.live_color : 2'd0;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      j_in         = j_ff;
      c_in         = c_ff;
      r_in         = r_ff;
      issue_in     = issue_ff;
      rd_grid_in   = rd_grid_ff;
      gen_in       = gen_ff;
      pop_in       = pop_ff;
      born_in      = born_ff;
      died_in      = died_ff;
      ppop_in      = ppop_ff;
      pborn_in     = pborn_ff;
      pdied_in     = pdied_ff;
      stag_in      = stag_ff;
      col_in       = col_ff;
      winl_in      = winl_ff;
      winc_in      = winc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      // read pipelines follow the issue side
      v1_in    = (state_ff == ST_SCAN) && issue_ff;
      dead1_in = cdead || rdead;
      last1_in = scan_last;
      r1_in    = r_ff;
      c1_in    = c_ff;
      j1_in    = j_ff;
      cv_in    = (state_ff == ST_COPY) && issue_ff;
      clast_in = copy_last;
      caddr_in = win_addr;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               rsp_in.read_value = 2'd0;
               rsp_in.generation = gen_ff;
               rsp_in.population = '0;
               rsp_in.births     = '0;
               rsp_in.deaths     = '0;
               rsp_in.stagnation = stag_ff;
               rsp_in.active     = 1'b0;
               case (req_data.op)
                  OP_WRITE: begin
                     rsp_valid_in = 1'b1;
                  end
                  OP_READ: begin
                     rd_grid_in = in_grid;
                     state_in   = ST_READ;
                  end
                  OP_STEP: begin
                     gen_in   = gen_ff + 16'd1;
                     w_in     = XW'(effw_e);
                     h_in     = YW'(effh_e);
                     j_in     = '0;
                     c_in     = '0;
                     r_in     = TAP_TOP;
                     pop_in   = '0;
                     born_in  = '0;
                     died_in  = '0;
                     if (effw_e != '0 && effh_e != '0) begin
                        issue_in = 1'b1;
                        state_in = ST_SCAN;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  OP_RESTART: begin
                     gen_in            = 16'd0;
                     rsp_in.generation = 16'd0;
                     rsp_in.active     = 1'b1;
                     rsp_valid_in      = 1'b1;
                  end
                  default: rsp_valid_in = 1'b0;
               endcase
            end
         end

         ST_READ: begin
            rsp_in.read_value = rd_grid_ff ? cur_rdata : 2'd0;
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end

         ST_SCAN: begin
            // issue side: three taps per column, halo columns at both ends
            if (issue_ff) begin
               if (r_ff != TAP_BOT) begin
                  r_in = r_ff + 2'd1;
               end else begin
                  r_in = TAP_TOP;
                  if (c_ff == c_wlast) begin
                     c_in = '0;
                     j_in = j_ff + YW'(1);
                     if (scan_last) begin
                        issue_in = 1'b0;
                     end
                  end else begin
                     c_in = c_ff + CXW'(1);
                  end
               end
            end
            // data side: collect taps, slide the window, count the cell
            if (v1_ff) begin
               col_in[r1_ff[0]] = live_bit;
            end
            if (col_done) begin
               winl_in = winc_ff;
               winc_in = full_col;
            end
            if (cell_do) begin
               if (keep && pop_ff != COUNT_MAX) begin
                  pop_in = pop_ff + 11'd1;
               end
               if (!alive && keep && born_ff != COUNT_MAX) begin
                  born_in = born_ff + 11'd1;
               end
               if (alive && !keep && died_ff != COUNT_MAX) begin
                  died_in = died_ff + 11'd1;
               end
            end
            if (v1_ff && last1_ff) begin
               j_in     = '0;
               c_in     = '0;
               issue_in = 1'b1;
               state_in = ST_COPY;
            end
         end

         ST_COPY: begin
            if (issue_ff) begin
               if (c_ff == CXW'(w_ff) - CXW'(1)) begin
                  c_in = '0;
                  j_in = j_ff + YW'(1);
                  if (copy_last) begin
                     issue_in = 1'b0;
                  end
               end else begin
                  c_in = c_ff + CXW'(1);
               end
            end
            if (cv_ff && clast_ff) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            rsp_in.read_value = 2'd0;
            rsp_in.generation = gen_ff;
            rsp_in.population = pop_ff;
            rsp_in.births     = born_ff;
            rsp_in.deaths     = died_ff;
            rsp_in.stagnation = stag_next;
            rsp_in.active     = (gen_ff != 16'd0) && (born_ff != '0 || died_ff != '0);
            stag_in           = stag_next;
            if (stat_eq) begin
               if (stag_next > 8'(STAG_LIMIT)) begin
                  ppop_in       = '0;
                  pborn_in      = '0;
                  pdied_in      = '0;
                  rsp_in.active = 1'b0;
               end
            end else begin
               ppop_in  = pop_ff;
               pborn_in = born_ff;
               pdied_in = died_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         issue_ff     <= 1'b0;
         v1_ff        <= 1'b0;
         cv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gen_ff       <= '0;
         ppop_ff      <= '0;
         pborn_ff     <= '0;
         pdied_ff     <= '0;
         stag_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issue_ff     <= issue_in;
         v1_ff        <= v1_in;
         cv_ff        <= cv_in;
         rsp_valid_ff <= rsp_valid_in;
         gen_ff       <= gen_in;
         ppop_ff      <= ppop_in;
         pborn_ff     <= pborn_in;
         pdied_ff     <= pdied_in;
         stag_ff      <= stag_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff       <= w_in;
      h_ff       <= h_in;
      j_ff       <= j_in;
      c_ff       <= c_in;
      r_ff       <= r_in;
      rd_grid_ff <= rd_grid_in;
      dead1_ff   <= dead1_in;
      last1_ff   <= last1_in;
      r1_ff      <= r1_in;
      c1_ff      <= c1_in;
      j1_ff      <= j1_in;
      col_ff     <= col_in;
      winl_ff    <= winl_in;
      winc_ff    <= winc_in;
      clast_ff   <= clast_in;
      caddr_ff   <= caddr_in;
      pop_ff     <= pop_in;
      born_ff    <= born_in;
      died_ff    <= died_in;
      rsp_ff     <= rsp_in;
   end

   // a read transfer moves on to ST_READ to wait for the grid data
   `LCA_ASSERT_NXT(a_read_waits, clock, reset, accept && req_data.op == OP_READ, state_ff == ST_READ)
   // results only leave while the sequencer is back at rest
   `LCA_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)
   // the current plane is never read and written in the same cycle
   `LCA_ASSERT_IMP(a_cur_port, clock, reset, cur_we, !cur_re)
   // scan data returns only during the scan
   `LCA_ASSERT_IMP(a_scan_data, clock, reset, v1_ff, state_ff == ST_SCAN)

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Life step unit. A driver feeds cell writes,
// reads, generation steps and counter restarts from a command queue and
// changes the window setup between phases. A shadow copy of the grid
// predicts every response. A monitor checks each strobed response
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import lca_pkg::*;

   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      req_type               cmd;
   } life_cmd_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   life_cmd_type pending_cmds[$];
   rsp_type      predicted_rsps[$];
   int           mismatch_count = 0;
   int           idle_gap = 0;
   int           quiet_cycles = 0;

   // Shadow state of the block
   logic [1:0]  grid_copy[GRID_W_DEFAULT*GRID_H_DEFAULT];
   logic [15:0] gen_copy = '0;
   logic [10:0] last_pop = '0, last_born = '0, last_died = '0;
   logic [7:0]  stag_copy = '0;
   cfg_type     cfg_copy = '{window_x: 5'd0, window_y: 5'd0, window_w: 6'd0,
                             window_h: 6'd0, wrap_edges: 1'b1, live_color: 2'd1};

   life_cellular_automaton_step_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      foreach (grid_copy[k]) grid_copy[k] = 2'd0;
   end

   // Apply B3/S23 to the window of the shadow grid, all cells from the old
   // generation at once.
   function automatic void life_generation(output logic [10:0] pop_o,
                                           output logic [10:0] born_o,
                                           output logic [10:0] died_o);
      logic [1:0] snap[GRID_W_DEFAULT*GRID_H_DEFAULT];
      int x0, y0, w, h, i, j, dx, dy, ni, nj, n, pop, born, died, idx;
      bit alive;
      x0 = cfg_copy.window_x;
      y0 = cfg_copy.window_y;
      w = (cfg_copy.window_w != 0) ? int'(cfg_copy.window_w) : GRID_W_DEFAULT;
      h = (cfg_copy.window_h != 0) ? int'(cfg_copy.window_h) : GRID_H_DEFAULT;
      pop = 0; born = 0; died = 0;
      // Cut a window that runs past the grid edge
      if (w > GRID_W_DEFAULT - x0) w = GRID_W_DEFAULT - x0;
      if (h > GRID_H_DEFAULT - y0) h = GRID_H_DEFAULT - y0;
      snap = grid_copy;
      for (j = 0; j < h; j++) begin
         for (i = 0; i < w; i++) begin
            n = 0;
            idx = (y0 + j) * GRID_W_DEFAULT + x0 + i;
            for (dy = -1; dy <= 1; dy++) begin
               nj = j + dy;
               if (nj < 0) begin
                  if (!cfg_copy.wrap_edges) continue;
                  nj = h - 1;
               end else if (nj >= h) begin
                  if (!cfg_copy.wrap_edges) continue;
                  nj = 0;
               end
               for (dx = -1; dx <= 1; dx++) begin
                  if (dx == 0 && dy == 0) continue;
                  ni = i + dx;
                  if (ni < 0) begin
                     if (!cfg_copy.wrap_edges) continue;
                     ni = w - 1;
                  end else if (ni >= w) begin
                     if (!cfg_copy.wrap_edges) continue;
                     ni = 0;
                  end
                  // A tiny wrapped window may count the same cell twice
                  if (snap[(y0 + nj) * GRID_W_DEFAULT + x0 + ni] == cfg_copy.live_color)
                     n++;
               end
            end
            alive = (snap[idx] == cfg_copy.live_color);
            if (alive && (n == 2 || n == 3)) begin
               grid_copy[idx] = cfg_copy.live_color;
               pop++;
            end else if (alive) begin
               grid_copy[idx] = 2'd0;
               died++;
            end else if (n == 3) begin
               grid_copy[idx] = cfg_copy.live_color;
               born++;
               pop++;
            end else begin
               grid_copy[idx] = 2'd0;
            end
         end
      end
      pop_o  = (pop  > 2047) ? COUNT_MAX : pop[10:0];
      born_o = (born > 2047) ? COUNT_MAX : born[10:0];
      died_o = (died > 2047) ? COUNT_MAX : died[10:0];
   endfunction

   // Advance the shadow state by one command and return its response.
   function automatic rsp_type life_predict(req_type cmd);
      rsp_type r;
      logic [10:0] pop, born, died;
      r = '0;
      case (cmd.op)
         OP_WRITE: grid_copy[cmd.cell_y * GRID_W_DEFAULT + cmd.cell_x] = cmd.write_value;
         OP_READ:  r.read_value = grid_copy[cmd.cell_y * GRID_W_DEFAULT + cmd.cell_x];
         OP_STEP: begin
            gen_copy = gen_copy + 16'd1;
            life_generation(pop, born, died);
            r.population = pop;
            r.births     = born;
            r.deaths     = died;
            r.active = (gen_copy != 0) && (born != 0 || died != 0);
            if (pop == last_pop && born == last_born && died == last_died) begin
               if (stag_copy != STAG_MAX) stag_copy = stag_copy + 8'd1;
               // Long stagnation: drop the remembered statistics, go inactive
               if (stag_copy > STAG_LIMIT) begin
                  last_pop = '0;
                  last_born = '0;
                  last_died = '0;
                  r.active = 1'b0;
               end
            end else begin
               last_pop = pop;
               last_born = born;
               last_died = died;
               stag_copy = '0;
            end
         end
         default: begin
            gen_copy = '0;
            r.active = 1'b1;
         end
      endcase
      r.generation = gen_copy;
      r.stagnation = stag_copy;
      return r;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_WINDOW_X:   cfg_copy.window_x   = val[4:0];
         CSR_WINDOW_Y:   cfg_copy.window_y   = val[4:0];
         CSR_WINDOW_W:   cfg_copy.window_w   = val[5:0];
         CSR_WINDOW_H:   cfg_copy.window_h   = val[5:0];
         CSR_WRAP_EDGES: cfg_copy.wrap_edges = val[0];
         CSR_LIVE_COLOR: cfg_copy.live_color = val[1:0];
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Driver: commands transfer on start && !busy, setup writes on
   // csr_valid && csr_ready, the latter only with nothing outstanding.
   always @(posedge clock) begin
      bit accepted, next_start, next_csr;
      life_cmd_type c;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         accepted = start && !busy;
         if (accepted) predicted_rsps.push_back(life_predict(req_data));
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_data);
         next_start = start && !accepted;
         next_csr = csr_valid && !csr_ready;
         if (!next_start && !next_csr) begin
            if (idle_gap > 0) begin
               idle_gap <= idle_gap - 1;
            end else if (pending_cmds.size() > 0) begin
               c = pending_cmds[0];
               if (!c.is_csr) begin
                  void'(pending_cmds.pop_front());
                  next_start = 1'b1;
                  req_data <= c.cmd;
                  idle_gap <= pick_gap();
               end else if (predicted_rsps.size() == 0 && !accepted && !busy
                            && quiet_cycles >= 8) begin
                  // Change setup only once the block has settled
                  void'(pending_cmds.pop_front());
                  next_csr = 1'b1;
                  csr_index <= c.csr_idx;
                  csr_data <= c.csr_val;
                  idle_gap <= pick_gap();
               end
            end
         end
         quiet_cycles <= (predicted_rsps.size() == 0 && !start && !next_start)
                         ? quiet_cycles + 1 : 0;
         start <= next_start;
         csr_valid <= next_csr;
      end
   end

   // Monitor: every strobed response must match the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (predicted_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %h", rsp_data);
         end else begin
            want = predicted_rsps.pop_front();
            if (rsp_data.read_value !== want.read_value ||
                rsp_data.generation !== want.generation ||
                rsp_data.population !== want.population ||
                rsp_data.births     !== want.births ||
                rsp_data.deaths     !== want.deaths ||
                rsp_data.stagnation !== want.stagnation ||
                rsp_data.active     !== want.active) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp rv=%0d gen=%0d pop=%0d born=%0d died=%0d",
                           want.read_value, want.generation, want.population,
                           want.births, want.deaths);
                  $display("          exp stag=%0d act=%0d",
                           want.stagnation, want.active);
                  $display("          got rv=%0d gen=%0d pop=%0d born=%0d died=%0d",
                           rsp_data.read_value, rsp_data.generation,
                           rsp_data.population, rsp_data.births, rsp_data.deaths);
                  $display("          got stag=%0d act=%0d",
                           rsp_data.stagnation, rsp_data.active);
               end
            end
         end
      end
   end

   function automatic void queue_cmd(op_type op, int x, int y, int v);
      life_cmd_type c;
      c = '{is_csr: 1'b0, csr_idx: '0, csr_val: '0, cmd: '0};
      c.cmd.op = op;
      c.cmd.cell_x = x[4:0];
      c.cmd.cell_y = y[4:0];
      c.cmd.write_value = v[1:0];
      pending_cmds.push_back(c);
   endfunction

   function automatic void queue_csr(logic [CSR_IDX_W-1:0] idx, int v);
      life_cmd_type c;
      c = '{is_csr: 1'b1, csr_idx: idx, csr_val: v[5:0], cmd: '0};
      pending_cmds.push_back(c);
   endfunction

   // Stimulus and end of run
   initial begin
      int p, k, r, wx, wy, ww, wh, wrap, color, spanx, spany;
      // Directed: corners, unwritten reads, a blinker stepped into stagnation
      queue_cmd(OP_WRITE, 0, 0, 3);
      queue_cmd(OP_WRITE, 31, 31, 1);
      queue_cmd(OP_READ, 0, 0, 0);
      queue_cmd(OP_READ, 31, 31, 2);
      queue_cmd(OP_READ, 17, 9, 0);
      queue_cmd(OP_WRITE, 15, 16, 1);
      queue_cmd(OP_WRITE, 16, 16, 1);
      queue_cmd(OP_WRITE, 17, 16, 1);
      for (k = 0; k < 7; k++) queue_cmd(OP_STEP, 0, 0, 0);
      queue_cmd(OP_READ, 16, 15, 0);
      queue_cmd(OP_RESTART, 0, 0, 0);
      queue_cmd(OP_STEP, 31, 31, 3);
      for (p = 1; p <= 12; p++) begin
         case (p)
            1: begin wx = 0;  wy = 0;  ww = 0;  wh = 0;  wrap = 0; color = 3; end
            2: begin wx = 31; wy = 31; ww = 1;  wh = 1;  wrap = 1; color = 2; end
            3: begin wx = 30; wy = 0;  ww = 2;  wh = 2;  wrap = 1; color = 0; end
            4: begin wx = 20; wy = 25; ww = 63; wh = 63; wrap = 1; color = 1; end
            5: begin wx = 0;  wy = 0;  ww = 32; wh = 32; wrap = 1; color = 2; end
            default: begin
               wx = $urandom_range(0, 63);
               wy = $urandom_range(0, 63);
               ww = $urandom_range(1, 12);
               wh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 12);
               wrap = $urandom_range(0, 63);
               color = $urandom_range(0, 63);
            end
         endcase
         queue_csr(CSR_WINDOW_X, wx);
         queue_csr(CSR_WINDOW_Y, wy);
         queue_csr(CSR_WINDOW_W, ww);
         queue_csr(CSR_WINDOW_H, wh);
         queue_csr(CSR_WRAP_EDGES, wrap);
         queue_csr(CSR_LIVE_COLOR, color);
         spanx = (ww[5:0] != 0) ? ww[5:0] : 32;
         spany = (wh[5:0] != 0) ? wh[5:0] : 32;
         if (spanx > 12) spanx = 12;
         if (spany > 12) spany = 12;
         // Mix writes that seed the window with steps, probes and restarts
         for (k = 0; k < 46; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
               queue_cmd(OP_WRITE, (wx[4:0] + $urandom_range(0, spanx - 1)) % 32,
                         (wy[4:0] + $urandom_range(0, spany - 1)) % 32,
                         ($urandom_range(0, 1) != 0) ? color[1:0] : $urandom_range(0, 3));
            else if (r < 68)
               queue_cmd(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 3));
            else if (r < 94)
               queue_cmd(OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 3));
            else
               queue_cmd(OP_RESTART, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 3));
         end
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_cmds.size() != 0 || predicted_rsps.size() != 0 || start || csr_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && predicted_rsps.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #100000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/lca_pkg.sv
design/lca_csr.sv
design/lca_mem.sv
design/life_cellular_automaton_step_unit.sv
sim/tb_top.sv
